>>> design/sam_pkg.sv
`default_nettype none

package sam_pkg;

  localparam int KEY_W  = 31;
  localparam int DATA_W = 32;

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic found;
    logic bucket_full;
    logic write_en;
  } lookup_stat_t;

endpackage

`default_nettype wire

>>> design/sam_bucket_index.sv
`default_nettype none

module sam_bucket_index
  import sam_pkg::*;
#(
  parameter int BUCKETS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic [KEY_W-1:0]     key_in,
  output logic      [KEY_W-1:0]     key_r,
  output logic      [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int  BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_in;
    end
  end

  generate
    if (BUCKETS == 1) begin : g_single
      assign bucket = '0;
    end else if (POW2) begin : g_pow2
      assign bucket = key_r[BW-1:0];
    end else begin : g_recip
      // The truncated reciprocal leaves the quotient at most one short, so the
      // remainder stays below twice the bucket count and one subtract fixes it.
      localparam int                SHIFT     = KEY_W + BW;
      localparam logic [63:0]       MULT_WIDE = (64'd1 << SHIFT) / 64'(BUCKETS);
      localparam logic [DATA_W-1:0] MULT      = MULT_WIDE[DATA_W-1:0];
      localparam logic [KEY_W-1:0]  B_K       = KEY_W'(BUCKETS);

      logic [KEY_W+DATA_W-1:0] prod_r;
      logic [KEY_W-1:0]        quot;
      logic [KEY_W-1:0]        quot_b;
      logic [KEY_W-1:0]        rem_raw;
      logic [KEY_W-1:0]        rem;

      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r <= (KEY_W+DATA_W)'(key_in) * (KEY_W+DATA_W)'(MULT);
        end
      end

      assign quot    = KEY_W'(prod_r >> SHIFT);
      assign quot_b  = quot * B_K;
      assign rem_raw = key_r - quot_b;
      assign rem     = (rem_raw >= B_K) ? (rem_raw - B_K) : rem_raw;
      assign bucket  = rem[BW-1:0];
    end
  endgenerate

endmodule

`default_nettype wire

>>> design/sam_store.sv
`default_nettype none

module sam_store
  import sam_pkg::*;
#(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rd_bucket,
  input  wire logic                         wr_en,
  input  wire logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] wr_bucket,
  input  wire logic [WAYS-1:0]              wr_valid,
  input  wire logic [WAYS*KEY_W-1:0]        wr_keys,
  input  wire logic [WAYS*DATA_W-1:0]       wr_data,
  output logic      [WAYS-1:0]              row_valid,
  output logic      [WAYS*KEY_W-1:0]        row_keys,
  output logic      [WAYS*DATA_W-1:0]       row_data,
  output logic                              clear_busy
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic [WAYS-1:0]        valid_mem [BUCKETS];
  logic [WAYS*KEY_W-1:0]  key_mem   [BUCKETS];
  logic [WAYS*DATA_W-1:0] data_mem  [BUCKETS];

  logic [WAYS-1:0]        rd_valid_r;
  logic [WAYS*KEY_W-1:0]  rd_keys_r;
  logic [WAYS*DATA_W-1:0] rd_data_r;

  logic                   fwd_r;
  logic                   fwd_nxt;
  logic [WAYS-1:0]        fwd_valid_r;
  logic [WAYS*KEY_W-1:0]  fwd_keys_r;
  logic [WAYS*DATA_W-1:0] fwd_data_r;

  logic                   clr_busy_r;
  logic                   clr_busy_nxt;
  logic [BW-1:0]          clr_cnt_r;
  logic [BW-1:0]          clr_cnt_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == BW'(BUCKETS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + BW'(1);
      end
    end
  end

  assign fwd_nxt = wr_en && (rd_bucket == wr_bucket);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      fwd_r      <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      if (rd_en) begin
        fwd_r <= fwd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      valid_mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      valid_mem[wr_bucket] <= wr_valid;
      key_mem[wr_bucket]   <= wr_keys;
      data_mem[wr_bucket]  <= wr_data;
    end
    if (rd_en) begin
      rd_valid_r  <= valid_mem[rd_bucket];
      rd_keys_r   <= key_mem[rd_bucket];
      rd_data_r   <= data_mem[rd_bucket];
      fwd_valid_r <= wr_valid;
      fwd_keys_r  <= wr_keys;
      fwd_data_r  <= wr_data;
    end
  end

  // A row written in the same cycle as it is read comes from the bypass.
  assign row_valid  = fwd_r ? fwd_valid_r : rd_valid_r;
  assign row_keys   = fwd_r ? fwd_keys_r  : rd_keys_r;
  assign row_data   = fwd_r ? fwd_data_r  : rd_data_r;
  assign clear_busy = clr_busy_r;

endmodule

`default_nettype wire

>>> design/sam_lookup.sv
`default_nettype none

module sam_lookup
  import sam_pkg::*;
#(
  parameter int WAYS = 4
) (
  input  wire op_t                    op,
  input  wire logic [KEY_W-1:0]       key,
  input  wire logic [DATA_W-1:0]      item_value,
  input  wire logic [WAYS-1:0]        row_valid,
  input  wire logic [WAYS*KEY_W-1:0]  row_keys,
  input  wire logic [WAYS*DATA_W-1:0] row_data,
  output logic      [DATA_W-1:0]      read_value,
  output lookup_stat_t                stat,
  output logic      [WAYS-1:0]        new_valid,
  output logic      [WAYS*KEY_W-1:0]  new_keys,
  output logic      [WAYS*DATA_W-1:0] new_data
);

  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   hit_oh;
  logic [WAYS-1:0]   free_oh;
  logic [DATA_W-1:0] hit_data;
  logic              is_assign;
  logic              found;
  logic              has_free;
  logic              insert;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_valid[w] && (row_keys[w*KEY_W +: KEY_W] == key);
    end
  end

  assign hit_oh    = hit_vec & (~hit_vec + WAYS'(1));
  assign free_oh   = ~row_valid & (row_valid + WAYS'(1));
  assign found     = |hit_vec;
  assign has_free  = ~&row_valid;
  assign is_assign = (op == OP_ASSIGN);
  assign insert    = is_assign && !found && has_free;

  always_comb begin
    hit_data  = '0;
    new_valid = row_valid;
    new_keys  = row_keys;
    new_data  = row_data;
    for (int w = 0; w < WAYS; w++) begin
      hit_data = hit_data | (row_data[w*DATA_W +: DATA_W] & {DATA_W{hit_oh[w]}});
      if (is_assign && hit_oh[w]) begin
        new_data[w*DATA_W +: DATA_W] = item_value;
      end
      if (insert && free_oh[w]) begin
        new_valid[w]                 = 1'b1;
        new_keys[w*KEY_W +: KEY_W]   = key;
        new_data[w*DATA_W +: DATA_W] = item_value;
      end
    end
  end

  assign read_value       = (op == OP_READ) ? hit_data : '0;
  assign stat.found       = found;
  assign stat.bucket_full = is_assign && !found && !has_free;
  assign stat.write_en    = is_assign && (found || has_free);

endmodule

`default_nettype wire

>>> design/sparse_array_map_unit.sv
// Pipeline: registers s1, s2 (with the bucket row) and the output. Throughput: one item
// per cycle while in_stall is low; the bucket row is read once per item and written back
// only by an assign that hits or inserts, and a row written while the next item reads it
// is passed on through a bypass register. Reset: synchronous active-low rst_n; then a
// clearing pass empties the valid bits one bucket row per cycle while in_stall is high.
`default_nettype none

module sparse_array_map_unit
  import sam_pkg::*;
#(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_operation,
  input  wire logic [KEY_W-1:0]         in_key,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic                          out_found,
  output logic                          out_bucket_full
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic                   adv;
  logic                   accept;
  logic                   clear_busy;

  logic                   s1_valid_r;
  op_t                    s1_op_r;
  logic [DATA_W-1:0]      s1_val_r;
  logic [KEY_W-1:0]       s1_key;
  logic [BW-1:0]          s1_bucket;

  logic                   s2_valid_r;
  op_t                    s2_op_r;
  logic [KEY_W-1:0]       s2_key_r;
  logic [DATA_W-1:0]      s2_val_r;
  logic [BW-1:0]          s2_bucket_r;

  logic [WAYS-1:0]        row_valid;
  logic [WAYS*KEY_W-1:0]  row_keys;
  logic [WAYS*DATA_W-1:0] row_data;
  logic [WAYS-1:0]        new_valid;
  logic [WAYS*KEY_W-1:0]  new_keys;
  logic [WAYS*DATA_W-1:0] new_data;
  logic [DATA_W-1:0]      lk_read_value;
  lookup_stat_t           lk_stat;
  logic                   wr_en;

  logic                   out_valid_r;
  logic [DATA_W-1:0]      out_read_value_r;
  logic                   out_found_r;
  logic                   out_bucket_full_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = clear_busy || !adv;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = adv && s2_valid_r && lk_stat.write_en;

  sam_bucket_index #(
    .BUCKETS (BUCKETS)
  ) u_index (
    .clk    (clk),
    .adv    (adv),
    .key_in (in_key),
    .key_r  (s1_key),
    .bucket (s1_bucket)
  );

  sam_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (adv),
    .rd_bucket  (s1_bucket),
    .wr_en      (wr_en),
    .wr_bucket  (s2_bucket_r),
    .wr_valid   (new_valid),
    .wr_keys    (new_keys),
    .wr_data    (new_data),
    .row_valid  (row_valid),
    .row_keys   (row_keys),
    .row_data   (row_data),
    .clear_busy (clear_busy)
  );

  sam_lookup #(
    .WAYS (WAYS)
  ) u_lookup (
    .op         (s2_op_r),
    .key        (s2_key_r),
    .item_value (s2_val_r),
    .row_valid  (row_valid),
    .row_keys   (row_keys),
    .row_data   (row_data),
    .read_value (lk_read_value),
    .stat       (lk_stat),
    .new_valid  (new_valid),
    .new_keys   (new_keys),
    .new_data   (new_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r           <= op_t'(in_operation);
      s1_val_r          <= DATA_W'(in_item_value);
      s2_op_r           <= s1_op_r;
      s2_key_r          <= s1_key;
      s2_val_r          <= s1_val_r;
      s2_bucket_r       <= s1_bucket;
      out_read_value_r  <= lk_read_value;
      out_found_r       <= lk_stat.found;
      out_bucket_full_r <= lk_stat.bucket_full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = DATA_W'(out_read_value_r);
  assign out_found       = out_found_r;
  assign out_bucket_full = out_bucket_full_r;

  a_no_work_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clear_busy |-> !s2_valid_r && !wr_en
  ) else $error("item in flight during the clearing pass");

  a_flags_exclusive : assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> !(out_found && out_bucket_full)
  ) else $error("found and bucket_full both set");

  a_miss_reads_zero : assert property (
    @(posedge clk) disable iff (!rst_n) out_valid && !out_found |-> out_read_value == '0
  ) else $error("nonzero read value without a hit");

  a_held_result_stable : assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> s2_valid_r == $past(s2_valid_r) && $stable(s2_key_r)
  ) else $error("pipeline moved while the result was held");

endmodule

`default_nettype wire

>>> tb/sv/sparse_array_map_unit_tb.sv
`default_nettype none

module sparse_array_map_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sam_pkg::*;

  localparam int BUCKETS = 64;
  localparam int WAYS = 4;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int RANDOM_PER_PHASE = 450;
  localparam int POOL_SIZE = 48;
  localparam int POOL_BUCKETS = 12;
  localparam int PROBES = 23;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic found;
    logic bucket_full;
  } map_reply_t;

  typedef struct {
    op_t op;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] value;
    bit typed;
    map_reply_t reply;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [KEY_W-1:0] in_key;
  logic signed [DATA_W-1:0] in_item_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic out_found;
  logic out_bucket_full;

  logic row_typed;
  map_reply_t row_reply;

  int tx_idle_pct = 14;
  int rx_stall_pct = 67;
  int mismatches = 0;

  bit shadow_valid [SLOTS];
  logic [KEY_W-1:0] shadow_key [SLOTS];
  logic [DATA_W-1:0] shadow_data [SLOTS];
  map_reply_t replies_due [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  probe_row_t probe_table [PROBES] = '{
    '{OP_READ,   31'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_READ,   31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h0000_0040, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h0000_0080, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h7FFF_FFC0, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h0000_00C0, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{OP_READ,   31'h0000_00C0, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_READ,   31'h0000_0000, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{OP_READ,   31'h0000_0040, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
    '{OP_READ,   31'h7FFF_FFC0, 32'h0000_0000, 1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
    '{OP_ASSIGN, 31'h0000_0040, 32'h0000_3039, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{OP_READ,   31'h0000_0040, 32'h0000_0000, 1'b1, '{32'h0000_3039, 1'b1, 1'b0}},
    '{OP_ASSIGN, 31'h7FFF_FFFF, 32'h5555_5555, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_READ,   31'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h5555_5555, 1'b1, 1'b0}},
    '{OP_READ,   31'h0000_003F, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{OP_ASSIGN, 31'h0000_0001, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_ASSIGN, 31'h0000_0041, 32'h0000_0007, 1'b0, '0},
    '{OP_READ,   31'h0000_0041, 32'h0000_0000, 1'b0, '0},
    '{OP_ASSIGN, 31'h0000_0041, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_READ,   31'h0000_0041, 32'h1234_5678, 1'b0, '0},
    '{OP_ASSIGN, 31'h0000_00C0, 32'h0000_0000, 1'b0, '0},
    '{OP_READ,   31'h0000_0001, 32'h0000_0000, 1'b0, '0}
  };

  sparse_array_map_unit #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_key(in_key),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_value(out_read_value),
    .out_found(out_found),
    .out_bucket_full(out_bucket_full)
  );

  always #2 clk = ~clk;

  function automatic map_reply_t apply_to_shadow_map(op_t op, logic [KEY_W-1:0] key,
                                                     logic [DATA_W-1:0] value);
    map_reply_t reply;
    int base;
    int hit_way;
    int free_way;
    reply = '0;
    base = int'(key % BUCKETS) * WAYS;
    hit_way = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit_way < 0 && shadow_key[base + w] == key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    reply.found = (hit_way >= 0);
    if (op == OP_READ) begin
      if (hit_way >= 0) reply.read_value = shadow_data[base + hit_way];
    end else if (hit_way >= 0) begin
      shadow_data[base + hit_way] = value;
    end else if (free_way >= 0) begin
      shadow_valid[base + free_way] = 1'b1;
      shadow_key[base + free_way] = key;
      shadow_data[base + free_way] = value;
    end else begin
      reply.bucket_full = 1'b1;
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    map_reply_t predicted;
    map_reply_t awaited;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      predicted = apply_to_shadow_map(op_t'(in_operation), in_key, in_item_value);
      replies_due.push_back(row_typed ? row_reply : predicted);
    end
    if (rst_n && $isunknown(out_valid)) begin
      $display("%0t: out_valid is unknown", $time);
      mismatches++;
    end else if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result transfer, read_value %0d found %0b full %0b",
                 $time, out_read_value, out_found, out_bucket_full);
        mismatches++;
      end else begin
        awaited = replies_due.pop_front();
        if (out_read_value !== awaited.read_value) begin
          $display("%0t: read_value expected %0d, actual %0d",
                   $time, awaited.read_value, out_read_value);
          mismatches++;
        end
        if (out_found !== awaited.found) begin
          $display("%0t: found expected %0b, actual %0b", $time, awaited.found, out_found);
          mismatches++;
        end
        if (out_bucket_full !== awaited.bucket_full) begin
          $display("%0t: bucket_full expected %0b, actual %0b",
                   $time, awaited.bucket_full, out_bucket_full);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic push_item(input op_t op, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] value, input bit typed,
                           input map_reply_t reply);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key <= key;
    in_item_value <= value;
    row_typed <= typed;
    row_reply <= reply;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] last_key;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_key = '0;
    in_item_value = '0;
    row_typed = 1'b0;
    row_reply = '0;
    last_key = '0;
    for (int s = 0; s < SLOTS; s++) shadow_valid[s] = 1'b0;
    for (int p = 0; p < POOL_SIZE; p++) begin
      key_pool[p] = KEY_W'($urandom);
      key_pool[p][5:0] = 6'(p % POOL_BUCKETS);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 67 : 0;
      rx_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 14 : 0;
      if (phase == 0) begin
        foreach (probe_table[i]) begin
          push_item(probe_table[i].op, probe_table[i].key, probe_table[i].value,
                    probe_table[i].typed, probe_table[i].reply);
        end
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 75) key = last_key;
        else key = KEY_W'($urandom);
        last_key = key;
        push_item(op_t'($urandom_range(1)), key, $urandom, 1'b0, '0);
      end
      in_valid <= 1'b0;
      @(posedge clk);
      while (replies_due.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, replies_due.size());
      mismatches += replies_due.size();
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/sam_pkg.sv
design/sam_bucket_index.sv
design/sam_store.sv
design/sam_lookup.sv
design/sparse_array_map_unit.sv
tb/sv/sparse_array_map_unit_tb.sv
